@@ design/cau_pkg.sv @@
// shared types and codes for the complex arithmetic unit
// no dependencies; used by every module of the block
package cau_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	// control that travels with an item down the divide chain
	typedef struct packed {
		logic valid;
		logic is_div;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
	} ctl_t;

endpackage

@@ design/complex_arithmetic_unit.sv @@
// top level of the complex arithmetic unit: front end, divide cell chain, output register
// depends on cau_pkg, cau_front and cau_cell
//
// Takes one operand item per clock and returns one result item per clock in
// order. Every operation passes through the same stages: operand register,
// product stage, sum and rounding stage, a chain of DATA_WIDTH + 1 division
// cells that each produce one quotient bit for both parts, and the output
// register. Add, subtract and multiply results ride along the chain
// unchanged. The whole pipeline holds while a result waits and out_ready is
// low.
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic [1:0]                   status
);

	localparam int DW = DATA_WIDTH;
	localparam int SW = 2 * DW;
	localparam int RW = SW + 1;
	localparam int QB = DW + 1;

	localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	cau_pkg::ctl_t    ctl    [0:QB];
	logic [DW-1:0]    pre_re [0:QB];
	logic [DW-1:0]    pre_im [0:QB];
	cau_pkg::status_t pre_st [0:QB];
	logic [SW-1:0]    den    [0:QB];
	logic [RW-1:0]    rem_re [0:QB];
	logic [RW-1:0]    rem_im [0:QB];
	logic [QB-1:0]    bits_re[0:QB];
	logic [QB-1:0]    bits_im[0:QB];
	logic [QB-1:0]    q_re   [0:QB];
	logic [QB-1:0]    q_im   [0:QB];

	assign q_re[0] = '0;
	assign q_im[0] = '0;

	cau_front #(
		.DATA_WIDTH(DATA_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_valid(in_valid),
		.req_type(req_type),
		.a_re    (a_re),
		.a_im    (a_im),
		.b_re    (b_re),
		.b_im    (b_im),
		.ctl     (ctl[0]),
		.pre_re  (pre_re[0]),
		.pre_im  (pre_im[0]),
		.pre_st  (pre_st[0]),
		.den     (den[0]),
		.rem_re  (rem_re[0]),
		.rem_im  (rem_im[0]),
		.bits_re (bits_re[0]),
		.bits_im (bits_im[0])
	);

	for (genvar i = 0; i < QB; i++) begin : g_cell
		cau_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl_i    (ctl[i]),
			.pre_re_i (pre_re[i]),
			.pre_im_i (pre_im[i]),
			.pre_st_i (pre_st[i]),
			.den_i    (den[i]),
			.rem_re_i (rem_re[i]),
			.rem_im_i (rem_im[i]),
			.bits_re_i(bits_re[i]),
			.bits_im_i(bits_im[i]),
			.q_re_i   (q_re[i]),
			.q_im_i   (q_im[i]),
			.ctl_o    (ctl[i+1]),
			.pre_re_o (pre_re[i+1]),
			.pre_im_o (pre_im[i+1]),
			.pre_st_o (pre_st[i+1]),
			.den_o    (den[i+1]),
			.rem_re_o (rem_re[i+1]),
			.rem_im_o (rem_im[i+1]),
			.bits_re_o(bits_re[i+1]),
			.bits_im_o(bits_im[i+1]),
			.q_re_o   (q_re[i+1]),
			.q_im_o   (q_im[i+1])
		);
	end

	// saturate the quotients and apply the sign
	cau_pkg::ctl_t c_l;
	logic [QB-1:0] qr, qi;
	logic          sr, si, nr, ni;
	logic [DW-1:0] dv_re, dv_im;

	always_comb begin
		c_l = ctl[QB];
		qr  = q_re[QB];
		qi  = q_im[QB];
		nr  = c_l.neg_re && (qr != '0 || c_l.ovf_re);
		ni  = c_l.neg_im && (qi != '0 || c_l.ovf_im);
		sr  = c_l.ovf_re || (nr ? (qr[QB-1:DW] != '0 || (qr[DW-1] && qr[DW-2:0] != '0))
			: (qr[QB-1:DW-1] != '0));
		si  = c_l.ovf_im || (ni ? (qi[QB-1:DW] != '0 || (qi[DW-1] && qi[DW-2:0] != '0))
			: (qi[QB-1:DW-1] != '0));
		dv_re = sr ? (nr ? MINV : MAXV) : (nr ? DW'(-qr) : qr[DW-1:0]);
		dv_im = si ? (ni ? MINV : MAXV) : (ni ? DW'(-qi) : qi[DW-1:0]);
	end

	logic             out_valid_q;
	logic [DW-1:0]    res_re_q, res_im_q;
	cau_pkg::status_t status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= c_l.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (c_l.is_div) begin
				res_re_q <= dv_re;
				res_im_q <= dv_im;
				status_q <= (sr || si) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
			end else begin
				res_re_q <= pre_re[QB];
				res_im_q <= pre_im[QB];
				status_q <= pre_st[QB];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res_re    = res_re_q;
	assign res_im    = res_im_q;
	assign status    = status_q;

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cau_pkg::ST_DIV0 |-> res_re == '0 && res_im == '0)
		else $error("divide by zero with nonzero result");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cau_pkg::ST_SAT |->
			res_re == MAXV || res_re == MINV || res_im == MAXV || res_im == MINV)
		else $error("saturated status without a part at a limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(status))
		else $error("result changed while stalled");

	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctl[0].valid))
		else $error("pipeline moved while stalled");

endmodule

@@ design/cau_front.sv @@
// front end: operand register, product stage and sum / rounding stage
// depends on cau_pkg; feeds the first divide cell
module cau_front #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           in_valid,
	input  logic [1:0]                     req_type,
	input  logic signed [DATA_WIDTH-1:0]   a_re,
	input  logic signed [DATA_WIDTH-1:0]   a_im,
	input  logic signed [DATA_WIDTH-1:0]   b_re,
	input  logic signed [DATA_WIDTH-1:0]   b_im,
	output cau_pkg::ctl_t                  ctl,
	output logic [DATA_WIDTH-1:0]          pre_re,
	output logic [DATA_WIDTH-1:0]          pre_im,
	output cau_pkg::status_t               pre_st,
	output logic [2*DATA_WIDTH-1:0]        den,
	output logic [2*DATA_WIDTH:0]          rem_re,
	output logic [2*DATA_WIDTH:0]          rem_im,
	output logic [DATA_WIDTH:0]            bits_re,
	output logic [DATA_WIDTH:0]            bits_im
);

	localparam int DW = DATA_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int SW = 2 * DW;
	localparam int RW = SW + 1;
	localparam int QB = DW + 1;
	localparam int NW = SW + FB;

	localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	// stage 1: operands
	logic                 valid_s1;
	cau_pkg::op_t         op_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// stage 2: products and add / subtract sums
	logic                 valid_s2;
	cau_pkg::op_t         op_s2;
	logic signed [SW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_bb_r_s2, p_bb_i_s2;
	logic signed [DW:0]   as_re_s2, as_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= cau_pkg::op_t'(req_type);
			ar_s1 <= a_re;
			ai_s1 <= a_im;
			br_s1 <= b_re;
			bi_s1 <= b_im;

			op_s2     <= op_s1;
			p_rr_s2   <= SW'(ar_s1 * br_s1);
			p_ii_s2   <= SW'(ai_s1 * bi_s1);
			p_ri_s2   <= SW'(ar_s1 * bi_s1);
			p_ir_s2   <= SW'(ai_s1 * br_s1);
			p_bb_r_s2 <= SW'(br_s1 * br_s1);
			p_bb_i_s2 <= SW'(bi_s1 * bi_s1);
			if (op_s1 == cau_pkg::OP_SUB) begin
				as_re_s2 <= (DW+1)'(ar_s1) - (DW+1)'(br_s1);
				as_im_s2 <= (DW+1)'(ai_s1) - (DW+1)'(bi_s1);
			end else begin
				as_re_s2 <= (DW+1)'(ar_s1) + (DW+1)'(br_s1);
				as_im_s2 <= (DW+1)'(ai_s1) + (DW+1)'(bi_s1);
			end
		end
	end

	// stage 3 logic
	logic signed [SW:0] m_re, m_im, n_re, n_im, sh_re, sh_im;
	logic [SW:0]        d_full;
	logic [SW-1:0]      d_c, nm_re, nm_im;
	logic [NW-1:0]      nn_re, nn_im;
	logic               ov_re, ov_im, ms_re, ms_im, as_sat_re, as_sat_im;
	logic [DW-1:0]      v_re, v_im;
	cau_pkg::status_t   st_c;

	always_comb begin
		m_re   = (SW+1)'(p_rr_s2) - (SW+1)'(p_ii_s2);
		m_im   = (SW+1)'(p_ri_s2) + (SW+1)'(p_ir_s2);
		n_re   = (SW+1)'(p_rr_s2) + (SW+1)'(p_ii_s2);
		n_im   = (SW+1)'(p_ir_s2) - (SW+1)'(p_ri_s2);
		d_full = {1'b0, p_bb_r_s2} + {1'b0, p_bb_i_s2};
		d_c    = d_full[SW-1:0];
		nm_re  = n_re[SW] ? SW'(-n_re) : n_re[SW-1:0];
		nm_im  = n_im[SW] ? SW'(-n_im) : n_im[SW-1:0];
		nn_re  = {nm_re, {FB{1'b0}}};
		nn_im  = {nm_im, {FB{1'b0}}};
		// quotient would not fit in QB bits: saturates anyway
		ov_re  = {{QB{1'b0}}, nn_re} >= {{FB{1'b0}}, d_c, {QB{1'b0}}};
		ov_im  = {{QB{1'b0}}, nn_im} >= {{FB{1'b0}}, d_c, {QB{1'b0}}};

		// multiply: floor shift, then range check on the upper bits
		sh_re = m_re >>> FB;
		sh_im = m_im >>> FB;
		ms_re = (sh_re[SW:DW-1] != {(SW-DW+2){1'b0}}) &&
			(sh_re[SW:DW-1] != {(SW-DW+2){1'b1}});
		ms_im = (sh_im[SW:DW-1] != {(SW-DW+2){1'b0}}) &&
			(sh_im[SW:DW-1] != {(SW-DW+2){1'b1}});
		as_sat_re = as_re_s2[DW] != as_re_s2[DW-1];
		as_sat_im = as_im_s2[DW] != as_im_s2[DW-1];

		v_re = '0;
		v_im = '0;
		st_c = cau_pkg::ST_OK;
		unique case (op_s2) inside
			cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
				v_re = as_sat_re ? (as_re_s2[DW] ? MINV : MAXV) : as_re_s2[DW-1:0];
				v_im = as_sat_im ? (as_im_s2[DW] ? MINV : MAXV) : as_im_s2[DW-1:0];
				if (as_sat_re || as_sat_im)
					st_c = cau_pkg::ST_SAT;
			end
			cau_pkg::OP_MUL: begin
				v_re = ms_re ? (sh_re[SW] ? MINV : MAXV) : sh_re[DW-1:0];
				v_im = ms_im ? (sh_im[SW] ? MINV : MAXV) : sh_im[DW-1:0];
				if (ms_re || ms_im)
					st_c = cau_pkg::ST_SAT;
			end
			cau_pkg::OP_DIV: begin
				if (d_c == '0)
					st_c = cau_pkg::ST_DIV0;
			end
			default: st_c = cau_pkg::ST_OK;
		endcase
	end

	// stage 3 registers: head of the divide chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl <= '0;
		else if (adv) begin
			ctl.valid  <= valid_s2;
			ctl.is_div <= (op_s2 == cau_pkg::OP_DIV) && (d_c != '0);
			ctl.neg_re <= n_re[SW];
			ctl.neg_im <= n_im[SW];
			ctl.ovf_re <= ov_re;
			ctl.ovf_im <= ov_im;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_re     <= v_re;
			pre_im     <= v_im;
			pre_st     <= st_c;
			den        <= d_c;
			rem_re     <= RW'(nn_re >> QB);
			rem_im     <= RW'(nn_im >> QB);
			bits_re    <= nn_re[QB-1:0];
			bits_im    <= nn_im[QB-1:0];
		end
	end

endmodule

@@ design/cau_cell.sv @@
// one restoring-division cell: one quotient bit for each part per item
// depends on cau_pkg; chained in the top level
module cau_cell #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  cau_pkg::ctl_t            ctl_i,
	input  logic [DATA_WIDTH-1:0]    pre_re_i,
	input  logic [DATA_WIDTH-1:0]    pre_im_i,
	input  cau_pkg::status_t         pre_st_i,
	input  logic [2*DATA_WIDTH-1:0]  den_i,
	input  logic [2*DATA_WIDTH:0]    rem_re_i,
	input  logic [2*DATA_WIDTH:0]    rem_im_i,
	input  logic [DATA_WIDTH:0]      bits_re_i,
	input  logic [DATA_WIDTH:0]      bits_im_i,
	input  logic [DATA_WIDTH:0]      q_re_i,
	input  logic [DATA_WIDTH:0]      q_im_i,
	output cau_pkg::ctl_t            ctl_o,
	output logic [DATA_WIDTH-1:0]    pre_re_o,
	output logic [DATA_WIDTH-1:0]    pre_im_o,
	output cau_pkg::status_t         pre_st_o,
	output logic [2*DATA_WIDTH-1:0]  den_o,
	output logic [2*DATA_WIDTH:0]    rem_re_o,
	output logic [2*DATA_WIDTH:0]    rem_im_o,
	output logic [DATA_WIDTH:0]      bits_re_o,
	output logic [DATA_WIDTH:0]      bits_im_o,
	output logic [DATA_WIDTH:0]      q_re_o,
	output logic [DATA_WIDTH:0]      q_im_o
);

	localparam int SW = 2 * DATA_WIDTH;
	localparam int RW = SW + 1;
	localparam int QB = DATA_WIDTH + 1;

	logic [RW-1:0] t_re, t_im;
	logic          ge_re, ge_im;

	always_comb begin
		// remainder stays below the divisor, so the shift never loses a bit
		t_re  = {rem_re_i[RW-2:0], bits_re_i[QB-1]};
		t_im  = {rem_im_i[RW-2:0], bits_im_i[QB-1]};
		ge_re = t_re >= {1'b0, den_i};
		ge_im = t_im >= {1'b0, den_i};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_o <= '0;
		else if (adv)
			ctl_o <= ctl_i;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_re_o     <= pre_re_i;
			pre_im_o     <= pre_im_i;
			pre_st_o     <= pre_st_i;
			den_o        <= den_i;
			rem_re_o     <= ge_re ? t_re - {1'b0, den_i} : t_re;
			rem_im_o     <= ge_im ? t_im - {1'b0, den_i} : t_im;
			bits_re_o    <= {bits_re_i[QB-2:0], 1'b0};
			bits_im_o    <= {bits_im_i[QB-2:0], 1'b0};
			q_re_o       <= {q_re_i[QB-2:0], ge_re};
			q_im_o       <= {q_im_i[QB-2:0], ge_im};
		end
	end

endmodule
